// ===== sv/mck_pkg.sv =====
// mck_pkg: shared types, constants and the Morse element table of the keyer
// used by the channel interfaces, mck_in_stage, mck_step and morse_code_keyer
// no dependencies
package mck_pkg;

    // message store geometry
    localparam int MSG_DEPTH = 16;
    localparam int IDX_W     = $clog2(MSG_DEPTH);
    localparam int POS_W     = $clog2(MSG_DEPTH + 1);

    // timing
    localparam int DIT_W     = 14;
    localparam int TIMER_W   = 16;
    localparam int LIM_W     = DIT_W + 3;
    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
    localparam logic [DIT_W-1:0]   DIT_RESET = DIT_W'(20);

    // character codes
    localparam logic [7:0] CHAR_FIRST = 8'd44;   // ','
    localparam logic [7:0] CHAR_LAST  = 8'd90;   // 'Z'
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef enum logic [3:0] {
        KS_DIT       = 4'd1,
        KS_DAH       = 4'd2,
        KS_BITGAP    = 4'd3,
        KS_LETTERGAP = 4'd4,
        KS_SPACE     = 4'd5,
        KS_NEXTBIT   = 4'd6,
        KS_NEXTCHAR  = 4'd7,
        KS_START     = 4'd8,
        KS_STOP      = 4'd9
    } t_ks;

    typedef enum logic [1:0] {
        EL_END = 2'd0,
        EL_DIT = 2'd1,
        EL_DAH = 2'd2
    } t_elem;

    typedef struct packed {
        logic       start_request;
        logic       stop_request;
        logic       write_enable;
        logic [3:0] write_index;
        logic [7:0] write_char;
    } t_in_word;

    typedef struct packed {
        logic beeper_on;
        logic idle;
    } t_out_word;

    // element idx of character ch: row is element count and dah mask (bit 0 first)
    function automatic t_elem code_element(input logic [7:0] ch, input logic [2:0] idx);
        logic [2:0] len;
        logic [6:0] mask;
        len  = 3'd0;
        mask = 7'h00;
        case (ch)
            8'd44: begin len = 3'd6; mask = 7'h33; end   // ,
            8'd46: begin len = 3'd6; mask = 7'h2A; end   // .
            8'd47: begin len = 3'd5; mask = 7'h09; end   // /
            8'd48: begin len = 3'd5; mask = 7'h1F; end   // 0
            8'd49: begin len = 3'd5; mask = 7'h1E; end
            8'd50: begin len = 3'd5; mask = 7'h1C; end
            8'd51: begin len = 3'd5; mask = 7'h18; end
            8'd52: begin len = 3'd5; mask = 7'h10; end
            8'd53: begin len = 3'd5; mask = 7'h00; end
            8'd54: begin len = 3'd5; mask = 7'h01; end
            8'd55: begin len = 3'd5; mask = 7'h03; end
            8'd56: begin len = 3'd5; mask = 7'h07; end
            8'd57: begin len = 3'd5; mask = 7'h0F; end   // 9
            8'd61: begin len = 3'd5; mask = 7'h11; end   // =
            8'd63: begin len = 3'd6; mask = 7'h0C; end   // ?
            8'd65: begin len = 3'd2; mask = 7'h02; end   // A
            8'd66: begin len = 3'd4; mask = 7'h01; end
            8'd67: begin len = 3'd4; mask = 7'h05; end
            8'd68: begin len = 3'd3; mask = 7'h01; end
            8'd69: begin len = 3'd1; mask = 7'h00; end
            8'd70: begin len = 3'd4; mask = 7'h04; end
            8'd71: begin len = 3'd3; mask = 7'h03; end
            8'd72: begin len = 3'd4; mask = 7'h00; end
            8'd73: begin len = 3'd2; mask = 7'h00; end
            8'd74: begin len = 3'd4; mask = 7'h0E; end
            8'd75: begin len = 3'd3; mask = 7'h05; end
            8'd76: begin len = 3'd4; mask = 7'h02; end
            8'd77: begin len = 3'd2; mask = 7'h03; end
            8'd78: begin len = 3'd2; mask = 7'h01; end
            8'd79: begin len = 3'd3; mask = 7'h07; end
            8'd80: begin len = 3'd4; mask = 7'h06; end
            8'd81: begin len = 3'd4; mask = 7'h0B; end
            8'd82: begin len = 3'd3; mask = 7'h02; end
            8'd83: begin len = 3'd3; mask = 7'h00; end
            8'd84: begin len = 3'd1; mask = 7'h01; end
            8'd85: begin len = 3'd3; mask = 7'h04; end
            8'd86: begin len = 3'd4; mask = 7'h08; end
            8'd87: begin len = 3'd3; mask = 7'h06; end
            8'd88: begin len = 3'd4; mask = 7'h09; end
            8'd89: begin len = 3'd4; mask = 7'h0D; end
            8'd90: begin len = 3'd4; mask = 7'h03; end   // Z
            default: begin len = 3'd0; mask = 7'h00; end
        endcase
        if (idx < len)
            return mask[idx] ? EL_DAH : EL_DIT;
        else
            return EL_END;
    endfunction

endpackage

// ===== sv/mck_in_if.sv =====
// mck_in_if: valid/ready channel carrying one tick word into the keyer
// depends on mck_pkg
interface mck_in_if
    import mck_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/mck_out_if.sv =====
// mck_out_if: valid/ready channel carrying one result word out of the keyer
// depends on mck_pkg
interface mck_out_if
    import mck_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/morse_code_keyer.sv =====
// morse_code_keyer: top level of the Morse keyer
// depends on mck_pkg, mck_in_if, mck_out_if, mck_in_stage and mck_step
//
// Usage:
//   i_in carries one tick word per handshake: start and stop requests and an
//   optional write of one character into the 16-entry message store. Each
//   accepted word advances the keyer by exactly one step and yields one result
//   word on o_out with beeper_on and idle.
//   i_cfg_we / i_cfg_data set the dit length in ticks; write it only while the
//   keyer is idle and no result is outstanding.
//   A word accepted on i_in passes the input register, then the step logic
//   into the result register.
//   Throughput: one word per cycle while o_out is ready, set by the single
//   state step between the input register and the result register.
//   Reset (synchronous, active low): keyer stopped, beeper off, message store
//   all terminators, dit length 20 ticks.
//   When o_out stalls, the result register holds its word and one more word
//   waits in the input register; then i_in.ready drops until o_out moves.
module morse_code_keyer
    import mck_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [DIT_W-1:0] i_cfg_data,
    mck_in_if.sink           i_in,
    mck_out_if.source        o_out
);

    mck_in_if u_mid ();

    // input register
    mck_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_up    (i_in),
        .o_down  (u_mid)
    );

    // keyer step and result register
    mck_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (u_mid),
        .o_out      (o_out)
    );

endmodule

// ===== sv/mck_in_stage.sv =====
// mck_in_stage: input register of the keyer, holds one tick word
// depends on mck_pkg and mck_in_if
module mck_in_stage
    import mck_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mck_in_if.sink      i_up,
    mck_in_if.source    o_down
);

    logic     r_valid;
    t_in_word r_word;

    // take a new word when empty or when the held word moves on
    assign i_up.ready   = !r_valid || o_down.ready;
    assign o_down.valid = r_valid;
    assign o_down.data  = r_word;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_up.ready) begin
            r_valid <= i_up.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_up.ready && i_up.valid) begin
            r_word <= i_up.data;
        end
    end

endmodule

// ===== sv/mck_step.sv =====
// mck_step: keyer state machine, message store, timing limits and result register
// depends on mck_pkg, mck_in_if and mck_out_if
module mck_step
    import mck_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [DIT_W-1:0] i_cfg_data,
    mck_in_if.sink           i_in,
    mck_out_if.source        o_out
);

    // state
    t_ks                r_state, n_state;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic [2:0]         r_eidx, n_eidx;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [7:0]         r_char, n_char;
    logic               r_beep, n_beep;
    logic [7:0]         r_store [MSG_DEPTH];

    // phase limits, dit_ticks times 1, 2, 3 and 6
    logic [LIM_W-1:0]   r_lim1, r_lim2, r_lim3, r_lim6;

    // result register
    logic               r_out_valid;
    t_out_word          r_out;

    // step control
    logic               advance;
    t_ks                s_eff;
    logic [TIMER_W-1:0] timer_inc;
    logic [LIM_W-1:0]   lim;
    logic               done;
    t_elem              el;
    logic               wr_hit;
    logic [7:0]         fetch_ch;
    logic [LIM_W-1:0]   cfg_x3;

    t_in_word           w;
    assign w = i_in.data;

    // one step per word once the result register is free
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign advance     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // write hit on the fetched position, store write comes first in a tick
    assign wr_hit = w.write_enable && (int'(w.write_index) < MSG_DEPTH) &&
                    (POS_W'(w.write_index) == r_pos);

    always_comb begin
        if (wr_hit)
            fetch_ch = w.write_char;
        else if (int'(r_pos) < MSG_DEPTH)
            fetch_ch = r_store[r_pos[IDX_W-1:0]];
        else
            fetch_ch = 8'd0;
    end

    assign el        = code_element(r_char, r_eidx);
    assign timer_inc = (r_timer != TIMER_MAX) ? r_timer + TIMER_W'(1) : r_timer;

    // requests, then one state step
    always_comb begin
        n_timer = r_timer;
        n_eidx  = r_eidx;
        n_pos   = r_pos;
        n_char  = r_char;
        n_beep  = r_beep;
        s_eff   = r_state;
        if (w.stop_request) begin
            s_eff  = KS_STOP;
            n_beep = 1'b0;
        end else if (w.start_request && r_state == KS_STOP) begin
            s_eff = KS_START;
        end
        n_state = s_eff;

        case (s_eff)
            KS_DAH:       lim = r_lim3;
            KS_LETTERGAP: lim = r_lim2;
            KS_SPACE:     lim = r_lim6;
            default:      lim = r_lim1;
        endcase
        done = ({1'b0, timer_inc} > lim) || (timer_inc == TIMER_MAX);

        case (s_eff)
            KS_DIT, KS_DAH: begin
                if (r_timer == '0)
                    n_beep = 1'b1;
                n_timer = timer_inc;
                if (done) begin
                    n_timer = '0;
                    n_state = KS_BITGAP;
                end
            end
            KS_BITGAP: begin
                if (r_timer == '0)
                    n_beep = 1'b0;
                n_timer = timer_inc;
                if (done)
                    n_state = KS_NEXTBIT;
            end
            KS_LETTERGAP, KS_SPACE: begin
                if (r_timer == '0)
                    n_beep = 1'b0;
                n_timer = timer_inc;
                if (done)
                    n_state = KS_NEXTCHAR;
            end
            KS_NEXTBIT: begin
                n_timer = '0;
                n_eidx  = r_eidx + 3'd1;
                case (el)
                    EL_DIT: n_state = KS_DIT;
                    EL_DAH: n_state = KS_DAH;
                    default: begin
                        n_state = KS_LETTERGAP;
                        n_eidx  = 3'd0;
                    end
                endcase
            end
            KS_NEXTCHAR: begin
                if (int'(r_pos) >= MSG_DEPTH) begin
                    n_char  = 8'd0;
                    n_state = KS_STOP;
                end else begin
                    n_char = fetch_ch;
                    n_pos  = r_pos + POS_W'(1);
                    if (fetch_ch == CHAR_SPACE) begin
                        n_timer = '0;
                        n_state = KS_SPACE;
                    end else if (fetch_ch < CHAR_FIRST || fetch_ch > CHAR_LAST) begin
                        n_state = KS_STOP;
                    end else begin
                        n_state = KS_NEXTBIT;
                    end
                end
            end
            KS_START: begin
                n_beep  = 1'b0;
                n_timer = '0;
                n_eidx  = 3'd0;
                n_pos   = '0;
                n_state = KS_NEXTCHAR;
            end
            KS_STOP: begin
                n_beep = 1'b0;
            end
            default: begin
                n_state = KS_STOP;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= KS_STOP;
            r_timer <= '0;
            r_eidx  <= 3'd0;
            r_pos   <= '0;
            r_char  <= 8'd0;
            r_beep  <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
            r_timer <= n_timer;
            r_eidx  <= n_eidx;
            r_pos   <= n_pos;
            r_char  <= n_char;
            r_beep  <= n_beep;
        end
    end

    // message store, cleared to terminators at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MSG_DEPTH; i++)
                r_store[i] <= 8'd0;
        end else if (advance && w.write_enable && int'(w.write_index) < MSG_DEPTH) begin
            r_store[w.write_index[IDX_W-1:0]] <= w.write_char;
        end
    end

    // limits follow each dit length write
    assign cfg_x3 = LIM_W'(i_cfg_data) + LIM_W'({i_cfg_data, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim1 <= LIM_W'(DIT_RESET);
            r_lim2 <= LIM_W'(DIT_RESET) << 1;
            r_lim3 <= LIM_W'(DIT_RESET) * LIM_W'(3);
            r_lim6 <= LIM_W'(DIT_RESET) * LIM_W'(6);
        end else if (i_cfg_we) begin
            r_lim1 <= LIM_W'(i_cfg_data);
            r_lim2 <= LIM_W'({i_cfg_data, 1'b0});
            r_lim3 <= cfg_x3;
            r_lim6 <= {cfg_x3[LIM_W-2:0], 1'b0};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.beeper_on <= n_beep;
            r_out.idle      <= (n_state == KS_STOP);
        end
    end

endmodule

// ===== tb/mck_checker.sv =====
`timescale 1ns / 100ps
// mck_checker: watches the keyer channels, predicts beeper and idle per tick word
// and compares them in order; depends on mck_pkg, mck_in_if and mck_out_if
module mck_checker
    import mck_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [DIT_W-1:0] i_cfg_data,
    mck_in_if                i_in_mon,
    mck_out_if               i_out_mon,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int unsigned DIT_AT_RESET = 20;
    localparam int unsigned TIMER_CEIL   = 65535;
    localparam logic [7:0]  CH_LOW       = 8'd44;
    localparam logic [7:0]  CH_HIGH      = 8'd90;
    localparam logic [7:0]  CH_BLANK     = " ";

    // predicted keyer state
    t_ks         key_state;
    int unsigned dit_len;
    int unsigned tone_timer;
    int unsigned elem_idx;
    int unsigned msg_pos;
    logic [7:0]  cur_char;
    logic [7:0]  msg_mem [MSG_DEPTH];
    logic        beep;

    // beeper and idle levels still owed by the keyer, oldest first
    t_out_word   owed_levels[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic clear_keyer();
        key_state  = KS_STOP;
        dit_len    = DIT_AT_RESET;
        tone_timer = 0;
        elem_idx   = 0;
        msg_pos    = 0;
        cur_char   = 8'h00;
        beep       = 1'b0;
        foreach (msg_mem[i])
            msg_mem[i] = 8'h00;
        owed_levels.delete();
    endtask

    // ITU elements of a character, dits as '.' and dahs as '-'
    function automatic string morse_pattern(input logic [7:0] ch);
        string pat;
        pat = "";
        case (ch)
            ",": pat = "--..--";
            ".": pat = ".-.-.-";
            "/": pat = "-..-.";
            "0": pat = "-----";
            "1": pat = ".----";
            "2": pat = "..---";
            "3": pat = "...--";
            "4": pat = "....-";
            "5": pat = ".....";
            "6": pat = "-....";
            "7": pat = "--...";
            "8": pat = "---..";
            "9": pat = "----.";
            "=": pat = "-...-";
            "?": pat = "..--..";
            "A": pat = ".-";
            "B": pat = "-...";
            "C": pat = "-.-.";
            "D": pat = "-..";
            "E": pat = ".";
            "F": pat = "..-.";
            "G": pat = "--.";
            "H": pat = "....";
            "I": pat = "..";
            "J": pat = ".---";
            "K": pat = "-.-";
            "L": pat = ".-..";
            "M": pat = "--";
            "N": pat = "-.";
            "O": pat = "---";
            "P": pat = ".--.";
            "Q": pat = "--.-";
            "R": pat = ".-.";
            "S": pat = "...";
            "T": pat = "-";
            "U": pat = "..-";
            "V": pat = "...-";
            "W": pat = ".--";
            "X": pat = "-..-";
            "Y": pat = "-.--";
            "Z": pat = "--..";
            default: pat = "";
        endcase
        return pat;
    endfunction

    function automatic t_elem element_at(input logic [7:0] ch, input int unsigned idx);
        string pat;
        pat = morse_pattern(ch);
        if (idx >= pat.len())
            return EL_END;
        return (pat[idx] == "-") ? EL_DAH : EL_DIT;
    endfunction

    // count one tick of a timed phase, true once it has lasted dit_len*mult+1 ticks
    function automatic bit phase_over(input int unsigned mult);
        int unsigned limit;
        limit = dit_len * mult;
        if (tone_timer < TIMER_CEIL)
            tone_timer++;
        return (tone_timer > limit) || (tone_timer >= TIMER_CEIL);
    endfunction

    // one state step of the keyer
    task automatic advance_keyer();
        t_elem el;
        case (key_state)
            KS_DIT, KS_DAH: begin
                if (tone_timer == 0)
                    beep = 1'b1;
                if (phase_over((key_state == KS_DIT) ? 1 : 3)) begin
                    tone_timer = 0;
                    key_state  = KS_BITGAP;
                end
            end
            KS_BITGAP: begin
                if (tone_timer == 0)
                    beep = 1'b0;
                if (phase_over(1))
                    key_state = KS_NEXTBIT;
            end
            KS_LETTERGAP: begin
                if (tone_timer == 0)
                    beep = 1'b0;
                if (phase_over(2))
                    key_state = KS_NEXTCHAR;
            end
            KS_SPACE: begin
                if (tone_timer == 0)
                    beep = 1'b0;
                if (phase_over(6))
                    key_state = KS_NEXTCHAR;
            end
            KS_NEXTBIT: begin
                tone_timer = 0;
                el = element_at(cur_char, elem_idx);
                elem_idx = (elem_idx + 1) & 7;
                if (el == EL_DIT)
                    key_state = KS_DIT;
                else if (el == EL_DAH)
                    key_state = KS_DAH;
                else begin
                    key_state = KS_LETTERGAP;
                    elem_idx  = 0;
                end
            end
            KS_NEXTCHAR: begin
                if (msg_pos >= MSG_DEPTH) begin
                    cur_char  = 8'h00;
                    key_state = KS_STOP;
                end else begin
                    cur_char = msg_mem[msg_pos];
                    msg_pos++;
                    if (cur_char == CH_BLANK) begin
                        tone_timer = 0;
                        key_state  = KS_SPACE;
                    end else if (cur_char < CH_LOW || cur_char > CH_HIGH) begin
                        key_state = KS_STOP;
                    end else begin
                        key_state = KS_NEXTBIT;
                    end
                end
            end
            KS_START: begin
                beep       = 1'b0;
                tone_timer = 0;
                elem_idx   = 0;
                msg_pos    = 0;
                key_state  = KS_NEXTCHAR;
            end
            KS_STOP: beep = 1'b0;
            default: key_state = KS_STOP;
        endcase
    endtask

    // store write, then requests, then the step; queue the levels it leaves
    task automatic predict_tick(input t_in_word w);
        t_out_word lv;
        if (w.write_enable)
            msg_mem[w.write_index] = w.write_char;
        if (w.stop_request) begin
            key_state = KS_STOP;
            beep      = 1'b0;
        end else if (w.start_request && key_state == KS_STOP) begin
            key_state = KS_START;
        end
        advance_keyer();
        lv.beeper_on = beep;
        lv.idle      = (key_state == KS_STOP);
        owed_levels.push_back(lv);
    endtask

    // sample both channels and the register port at each rising edge
    always @(posedge i_clk) begin : watch
        t_out_word got;
        t_out_word want;
        if (!i_rst_n) begin
            clear_keyer();
        end else begin
            if (i_out_mon.valid === 1'b1 && i_out_mon.ready === 1'b1) begin
                got = i_out_mon.data;
                if (owed_levels.size() == 0) begin
                    report_mismatch($sformatf("result word with none expected (beeper %b idle %b)",
                                              got.beeper_on, got.idle));
                end else begin
                    want = owed_levels.pop_front();
                    if (got.beeper_on !== want.beeper_on)
                        report_mismatch($sformatf("beeper_on %b, expected %b",
                                                  got.beeper_on, want.beeper_on));
                    if (got.idle !== want.idle)
                        report_mismatch($sformatf("idle %b, expected %b", got.idle, want.idle));
                end
            end
            if (i_cfg_we)
                dit_len = i_cfg_data;
            if (i_in_mon.valid === 1'b1 && i_in_mon.ready === 1'b1)
                predict_tick(i_in_mon.data);
        end
        o_pending = owed_levels.size();
    end

endmodule

// ===== tb/morse_code_keyer_tb.sv =====
`timescale 1ns / 100ps
// morse_code_keyer_tb: drives tick words, dit settings and output stalls into the keyer
// depends on mck_pkg, mck_in_if, mck_out_if, morse_code_keyer and mck_checker
module morse_code_keyer_tb
    import mck_pkg::*;
();

    localparam int RANDOM_WORDS = 1300;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [DIT_W-1:0] i_cfg_data;
    int               fail_count;
    int               pending;

    int               words_sent;
    int               dit_settings;
    int               cur_dit;
    bit               steady;

    mck_in_if  in_ch ();
    mck_out_if out_ch ();

    morse_code_keyer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    mck_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #1000000;
        $display("timeout with %0d result words outstanding", pending);
        $display("Simulation FAILED");
        $finish;
    end

    // result side: ready runs broken by short and rare long stalls
    initial begin : result_sink
        int hold;
        int stall;
        int r;
        out_ch.ready = 1'b1;
        forever begin
            hold = $urandom_range(1, 40);
            if ($urandom_range(9) == 0)
                hold = 200;
            out_ch.ready = 1'b1;
            repeat (hold) @(negedge i_clk);
            r = $urandom_range(99);
            if (r < 45)
                stall = 0;
            else if (r < 90)
                stall = $urandom_range(1, 3);
            else
                stall = $urandom_range(10, 30);
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
        end
    end

    function automatic int sender_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // present one tick word at the falling edge and hold it until taken
    task automatic send_word(input bit start, input bit stop, input bit we,
                             input logic [3:0] idx, input logic [7:0] ch);
        int gap;
        gap = sender_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.data.start_request = start;
        in_ch.data.stop_request  = stop;
        in_ch.data.write_enable  = we;
        in_ch.data.write_index   = idx;
        in_ch.data.write_char    = ch;
        in_ch.valid              = 1'b1;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        words_sent++;
    endtask

    // plain tick: write index and char toggle but are not written
    task automatic plain_ticks(input int n);
        repeat (n) send_word(1'b0, 1'b0, 1'b0, 4'($urandom), 8'($urandom));
    endtask

    task automatic store_char(input int idx, input logic [7:0] ch);
        send_word(1'b0, 1'b0, 1'b1, 4'(idx), ch);
    endtask

    task automatic load_message(input string s);
        for (int i = 0; i < s.len(); i++)
            store_char(i, s[i]);
        if (s.len() < MSG_DEPTH)
            store_char(s.len(), 8'h00);
    endtask

    task automatic start_keyer();
        send_word(1'b1, 1'b0, 1'b0, 4'($urandom), 8'($urandom));
    endtask

    task automatic stop_keyer();
        send_word(1'b0, 1'b1, 1'b0, 4'($urandom), 8'($urandom));
    endtask

    task automatic noise_word();
        send_word($urandom_range(7) == 0, $urandom_range(9) == 0, 1'($urandom_range(1)),
                  4'($urandom), 8'($urandom_range(255)));
    endtask

    // hold off until every result word has come back
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // dit length is written only with the keyer stopped and nothing in flight
    task automatic set_dit(input int v);
        stop_keyer();
        drain();
        i_cfg_we   = 1'b1;
        i_cfg_data = DIT_W'(v);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        cur_dit    = v;
        dit_settings++;
    endtask

    function automatic logic [7:0] pick_char();
        string keyed;
        int    r;
        keyed = "ETIANMSURWDKGOHVFLPJBXCYZQ0123456789,./=?";
        r = $urandom_range(99);
        if (r < 70)
            return keyed[$urandom_range(keyed.len() - 1)];
        if (r < 80)
            return " ";
        if (r < 95)
            return 8'($urandom_range(44, 90));
        return 8'($urandom_range(255));
    endfunction

    function automatic int pick_dit();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return $urandom_range(1, 2);
        if (r < 92)
            return $urandom_range(3, 6);
        return $urandom_range(7, 10000);
    endfunction

    initial begin : stimulus
        int random_base;
        int runs;
        int n;
        int len;
        int top_len;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        i_rst_n      = 1'b0;
        words_sent   = 0;
        dit_settings = 0;
        cur_dit      = 20;
        steady       = 1'b0;
        runs         = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset dit length: start and stop together, then a short busy run
        send_word(1'b1, 1'b1, 1'b0, 4'hF, 8'hFF);
        store_char(0, "T");
        start_keyer();
        start_keyer();
        plain_ticks(25);
        stop_keyer();

        // shortest dit: char written at the position fetched in the same tick
        set_dit(1);
        store_char(0, "E");
        store_char(1, 8'h00);
        start_keyer();
        plain_ticks(10);
        store_char(1, "T");
        plain_ticks(14);

        // space, comma, codes with no elements, question mark, slash, code past Z
        load_message({"E ,-?@/", "["});
        start_keyer();
        plain_ticks(40);
        send_word(1'b1, 1'b1, 1'b0, 4'h0, 8'h00);
        start_keyer();
        plain_ticks(150);

        // first char out of range, then a full store ending at its last position
        store_char(0, 8'hFF);
        start_keyer();
        plain_ticks(3);
        for (int i = 0; i < MSG_DEPTH; i++)
            store_char(i, "E");
        start_keyer();
        plain_ticks(170);

        // longest dit: a dah cut short by a stop
        set_dit(10000);
        store_char(0, "0");
        start_keyer();
        plain_ticks(120);
        set_dit(pick_dit());

        // random part: mostly well formed messages with random content
        random_base = words_sent;
        while (words_sent - random_base < RANDOM_WORDS) begin
            runs++;
            steady = ($urandom_range(4) == 0);
            if (runs % 4 == 0)
                set_dit(pick_dit());
            if ($urandom_range(9) < 8) begin
                n = ($urandom_range(19) == 0) ? $urandom_range(5, MSG_DEPTH)
                                              : $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    store_char(i, pick_char());
                if (n < MSG_DEPTH && $urandom_range(4) != 0)
                    store_char(n, 8'h00);
                start_keyer();
                top_len = n * 36 * cur_dit + 10;
                if (top_len > 300)
                    top_len = 300;
                len = $urandom_range(10, top_len);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(19) == 0)
                        noise_word();
                    else
                        plain_ticks(1);
                end
                if ($urandom_range(1))
                    stop_keyer();
            end else begin
                repeat ($urandom_range(5, 30)) noise_word();
            end
            // the sender now and then waits for every result
            if ($urandom_range(7) == 0)
                drain();
        end

        steady = 1'b0;
        drain();
        repeat (6) @(negedge i_clk);
        $display("covered %0d tick words over %0d dit lengths, 1 and 10000 included",
                 words_sent, dit_settings + 1);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
